### sv/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types, states and helpers for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned AREA_W   = 2 * COORD_W;
  localparam int unsigned UNION_W  = AREA_W + 1;
  localparam int unsigned THR_W    = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

  // one stored box, score in the low lanes
  typedef struct packed {
    logic signed [COORD_W-1:0] bottom;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] left;
    logic        [SCORE_W-1:0] score;
  } box_t;

  // suppression verdict leaving the overlap unit
  typedef struct packed {
    logic valid;
    logic supp;
  } iou_res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MAX,
    ST_PREP,
    ST_AREA,
    ST_SUP,
    ST_EMIT
  } state_t;

  // length from a to b, zero when b does not lie above a
  function automatic logic [COORD_W-1:0] clamp_len(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] d;
    d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    return (b > a) ? d[COORD_W-1:0] : '0;
  endfunction

  function automatic logic signed [COORD_W-1:0] smax(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [COORD_W-1:0] smin(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

endpackage

### sv/gbs_box_if.sv
// ----------------------------------------------------------------------------
// gbs_box_if
// Input box channel: valid/ready with one detection box per beat.
// ----------------------------------------------------------------------------
interface gbs_box_if;
  logic               valid;
  logic               ready;
  logic        [15:0] score;
  logic signed [15:0] left_edge;
  logic signed [15:0] top_edge;
  logic signed [15:0] right_edge;
  logic signed [15:0] bottom_edge;
  logic               final_box;

  modport source (output valid, score, left_edge, top_edge, right_edge, bottom_edge,
                  final_box, input ready);
  modport sink   (input valid, score, left_edge, top_edge, right_edge, bottom_edge,
                  final_box, output ready);
endinterface

### sv/gbs_kept_if.sv
// ----------------------------------------------------------------------------
// gbs_kept_if
// Result channel: valid/ready with one kept box per beat.
// ----------------------------------------------------------------------------
interface gbs_kept_if;
  logic               valid;
  logic               ready;
  logic        [15:0] kept_score;
  logic signed [15:0] kept_left;
  logic signed [15:0] kept_top;
  logic signed [15:0] kept_right;
  logic signed [15:0] kept_bottom;
  logic               end_of_run;
  logic               overflowed;

  modport source (output valid, kept_score, kept_left, kept_top, kept_right, kept_bottom,
                  end_of_run, overflowed, input ready);
  modport sink   (input valid, kept_score, kept_left, kept_top, kept_right, kept_bottom,
                  end_of_run, overflowed, output ready);
endinterface

### sv/gbs_cfg_if.sv
// ----------------------------------------------------------------------------
// gbs_cfg_if
// Configuration write channel carrying the IoU threshold.
// ----------------------------------------------------------------------------
interface gbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### sv/gbs_box_mem.sv
// ----------------------------------------------------------------------------
// gbs_box_mem
// Box store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbs_box_mem
  import gbs_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  box_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  output box_t          rd_data
);

  box_t mem [DEPTH];

  // write one box
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data is registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/gbs_iou_unit.sv
// ----------------------------------------------------------------------------
// gbs_iou_unit
// Pipelined overlap test: decides whether a candidate box is suppressed
// by the kept box. Four register stages, one candidate per cycle.
// ----------------------------------------------------------------------------
module gbs_iou_unit
  import gbs_pkg::*;
#(
  parameter int unsigned AW = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [AW-1:0]      in_idx,
  input  box_t               cand,
  input  box_t               kept,
  input  logic [AREA_W-1:0]  kept_area,
  input  logic [THR_W-1:0]   thr,
  output iou_res_t           res,
  output logic [AW-1:0]      res_idx,
  output logic               busy
);

  logic [3:0]              v;
  logic [AW-1:0]           idx1, idx2, idx3, idx4;
  logic [COORD_W-1:0]      iw, ih, qw, qh;
  logic [AREA_W-1:0]       inter2, area2;
  logic [UNION_W-1:0]      uni3;
  logic [AREA_W-1:0]       inter3;
  logic [UNION_W+THR_W-1:0] prod4;
  logic [AREA_W+15:0]      lhs4;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], in_valid};
    end
  end

  // stage 1: overlap and candidate extents
  always_ff @(posedge clk) begin
    idx1 <= in_idx;
    iw   <= clamp_len(smax(kept.left, cand.left), smin(kept.right, cand.right));
    ih   <= clamp_len(smax(kept.top, cand.top), smin(kept.bottom, cand.bottom));
    qw   <= clamp_len(cand.left, cand.right);
    qh   <= clamp_len(cand.top, cand.bottom);
  end

  // stage 2: intersection and candidate area
  always_ff @(posedge clk) begin
    idx2   <= idx1;
    inter2 <= iw * ih;
    area2  <= qw * qh;
  end

  // stage 3: union
  always_ff @(posedge clk) begin
    idx3   <= idx2;
    inter3 <= inter2;
    uni3   <= UNION_W'({1'b0, kept_area} + {1'b0, area2} - {1'b0, inter2});
  end

  // stage 4: scale both sides of the comparison
  always_ff @(posedge clk) begin
    idx4  <= idx3;
    prod4 <= thr * uni3;
    lhs4  <= {inter3, 16'd0};
  end

  always_comb begin
    res.valid = v[3];
    res.supp  = !((UNION_W+THR_W)'(lhs4) < prod4);
  end

  assign res_idx = idx4;
  assign busy    = |v;

endmodule

### sv/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression over one set of boxes.
//
//   channel   dir  beat
//   box_in    in   score, left/top/right/bottom edges, final_box
//   kept_out  out  kept box, end_of_run, overflowed
//   cfg       in   IoU threshold, Q0.16
//
// Boxes load back to back while the input is open. After the final box
// each round makes one store sweep for the maximum and one sweep through
// the four-stage overlap unit, then offers the result beat. Both sweeps
// go through the single read port of the box store.
// Reset is synchronous and leaves the block empty, ready to load.
// The input is closed from the final box until the last kept box leaves.
// ----------------------------------------------------------------------------
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic        clk,
  input  logic        rst,
  gbs_box_if.sink     box_in,
  gbs_kept_if.source  kept_out,
  gbs_cfg_if.sink     cfg
);

  localparam int unsigned AW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_BOXES);

  state_t               state, state_next;
  logic [CW-1:0]        count;
  logic                 ovf;
  logic [MAX_BOXES-1:0] done_mask;
  logic [THR_W-1:0]     thr;
  logic [CW-1:0]        iss;
  logic                 v1;
  logic [AW-1:0]        idx1;
  logic                 done1;
  logic                 have_best;
  logic [AW-1:0]        best_idx;
  box_t                 best;
  logic [COORD_W-1:0]   bw, bh;
  logic [AREA_W-1:0]    area_p;
  logic                 any_left;

  logic                 in_beat, out_beat, issue, scan_end;
  box_t                 wr_box, rd_box;
  iou_res_t             ires;
  logic [AW-1:0]        ires_idx;
  logic                 ibusy;

  assign in_beat  = box_in.valid && box_in.ready;
  assign out_beat = kept_out.valid && kept_out.ready;
  assign issue    = ((state == ST_MAX) || (state == ST_SUP)) && (iss < count);
  assign scan_end = (iss == count) && !v1;

  assign wr_box.score  = box_in.score;
  assign wr_box.left   = box_in.left_edge;
  assign wr_box.top    = box_in.top_edge;
  assign wr_box.right  = box_in.right_edge;
  assign wr_box.bottom = box_in.bottom_edge;

  gbs_box_mem #(.DEPTH(MAX_BOXES), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (in_beat && (count < CAP)),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_box),
    .rd_addr (iss[AW-1:0]),
    .rd_data (rd_box)
  );

  gbs_iou_unit #(.AW(AW)) u_iou (
    .clk       (clk),
    .rst       (rst),
    .in_valid  ((state == ST_SUP) && v1 && !done1),
    .in_idx    (idx1),
    .cand      (rd_box),
    .kept      (best),
    .kept_area (area_p),
    .thr       (thr),
    .res       (ires),
    .res_idx   (ires_idx),
    .busy      (ibusy)
  );

  // ports
  assign box_in.ready         = (state == ST_LOAD);
  assign cfg.ready            = 1'b1;
  assign kept_out.valid       = (state == ST_EMIT);
  assign kept_out.kept_score  = best.score;
  assign kept_out.kept_left   = best.left;
  assign kept_out.kept_top    = best.top;
  assign kept_out.kept_right  = best.right;
  assign kept_out.kept_bottom = best.bottom;
  assign kept_out.end_of_run  = !any_left;
  assign kept_out.overflowed  = ovf;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: if (in_beat && box_in.final_box) state_next = ST_MAX;
      ST_MAX:  if (scan_end) state_next = have_best ? ST_PREP : ST_LOAD;
      ST_PREP: state_next = ST_AREA;
      ST_AREA: state_next = ST_SUP;
      ST_SUP:  if (scan_end && !ibusy) state_next = ST_EMIT;
      ST_EMIT: if (out_beat) state_next = any_left ? ST_MAX : ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      thr <= cfg.data;
    end
  end

  // count, overflow and done mask
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      done_mask <= '0;
    end else begin
      if (in_beat) begin
        if (count < CAP) begin
          count <= count + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if ((state == ST_MAX) && scan_end) begin
        if (have_best) begin
          done_mask[best_idx] <= 1'b1;
        end else begin
          count     <= '0;
          ovf       <= 1'b0;
          done_mask <= '0;
        end
      end
      if ((state == ST_SUP) && ires.valid && ires.supp) begin
        done_mask[ires_idx] <= 1'b1;
      end
      // clear the set once its last kept box has left
      if ((state == ST_EMIT) && out_beat && !any_left) begin
        count     <= '0;
        ovf       <= 1'b0;
        done_mask <= '0;
      end
    end
  end

  // sweep the store
  always_ff @(posedge clk) begin
    if (rst) begin
      iss <= '0;
      v1  <= 1'b0;
    end else begin
      v1 <= issue;
      if (issue) begin
        iss <= iss + 1'b1;
      end else if ((state == ST_LOAD) || (state == ST_AREA) || (state == ST_EMIT)) begin
        iss <= '0;
      end
    end
    idx1  <= iss[AW-1:0];
    done1 <= done_mask[iss[AW-1:0]];
  end

  // track the best box of a round, first index wins on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (state == ST_MAX) begin
      if (v1 && !done1 && (!have_best || (rd_box.score > best.score))) begin
        have_best <= 1'b1;
        best_idx  <= idx1;
        best      <= rd_box;
      end
    end else begin
      have_best <= 1'b0;
    end
  end

  // area of the kept box
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      bw <= clamp_len(best.left, best.right);
      bh <= clamp_len(best.top, best.bottom);
    end
    if (state == ST_AREA) begin
      area_p <= bw * bh;
    end
  end

  // note any survivor of the suppression sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      any_left <= 1'b0;
    end else if (state == ST_AREA) begin
      any_left <= 1'b0;
    end else if ((state == ST_SUP) && ires.valid && !ires.supp) begin
      any_left <= 1'b1;
    end
  end

endmodule

### sv/gbs_checker.sv
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks for greedy_box_suppression, bound to the top level.
// ----------------------------------------------------------------------------
module gbs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_final,
  input logic out_valid,
  input logic out_ready,
  input logic out_end,
  input logic out_ovf
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_ovf) && $stable(out_end))
    else $error("result beat dropped while stalled");

  // never load while results are offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input open during result phase");

  // close the input after the final box
  a_close: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_final |=> !in_ready)
    else $error("input still open after final box");

  // reopen only after the last kept box
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready == $past(out_end))
    else $error("input reopened at the wrong beat");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (box_in.valid),
  .in_ready  (box_in.ready),
  .in_final  (box_in.final_box),
  .out_valid (kept_out.valid),
  .out_ready (kept_out.ready),
  .out_end   (kept_out.end_of_run),
  .out_ovf   (kept_out.overflowed)
);

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks greedy box suppression: sets of boxes are loaded through the box
// channel, a local model predicts the kept boxes of each set, and every
// result beat is compared field by field against the oldest prediction.
// Covers threshold extremes, ties, degenerate boxes, overflow and stalls.
// ----------------------------------------------------------------------------
module tb;
  import gbs_pkg::*;

  localparam int unsigned CAP       = 64;
  localparam int unsigned STALL_MAX = 200000;

  typedef struct {
    logic [15:0]        score;
    logic signed [15:0] l, t, r, b;
    logic               eor, ovf;
  } kept_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gbs_box_if  box_in ();
  gbs_kept_if kept_out ();
  gbs_cfg_if  cfg ();

  greedy_box_suppression #(.MAX_BOXES(CAP)) uut (
    .clk(clk), .rst(rst), .box_in(box_in), .kept_out(kept_out), .cfg(cfg)
  );

  always #1 clk = ~clk;

  // model state
  logic [15:0] thr;
  box_t        held[CAP];
  int          n_held;
  logic        ovf_seen;
  kept_t       kept_q[$];

  int   errors;
  int   idle_cycles;
  int   send_idle_pct, recv_idle_pct;
  logic hold_off;

  // ---------------------------------------------------------------- model
  function automatic logic [31:0] span(logic signed [15:0] a, logic signed [15:0] b);
    int d;
    d = int'(b) - int'(a);
    return (d > 0) ? 32'(d) : 32'd0;
  endfunction

  function automatic bit overlaps_too_much(box_t p, box_t q, logic [15:0] th);
    logic [63:0] iw, ih, inter, ap, aq, un;
    iw    = span(p.left > q.left ? p.left : q.left, p.right < q.right ? p.right : q.right);
    ih    = span(p.top > q.top ? p.top : q.top, p.bottom < q.bottom ? p.bottom : q.bottom);
    inter = iw * ih;
    ap    = span(p.left, p.right) * span(p.top, p.bottom);
    aq    = span(q.left, q.right) * span(q.top, q.bottom);
    un    = ap + aq - inter;
    return !((inter << 16) < 64'(th) * un);
  endfunction

  // take in one box; on the final box work out the kept set
  task automatic predict_box(box_t bx, logic fin);
    bit done[CAP];
    int best, first_idx;
    if (n_held < CAP) begin
      held[n_held] = bx;
      n_held++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!fin) return;
    foreach (done[i]) done[i] = 0;
    first_idx = kept_q.size();
    forever begin
      kept_t k;
      best = -1;
      for (int i = 0; i < n_held; i++)
        if (!done[i] && (best < 0 || held[i].score > held[best].score)) best = i;
      if (best < 0) break;
      done[best] = 1;
      for (int i = 0; i < n_held; i++)
        if (!done[i] && overlaps_too_much(held[best], held[i], thr)) done[i] = 1;
      k.score = held[best].score; k.l = held[best].left; k.t = held[best].top;
      k.r = held[best].right; k.b = held[best].bottom;
      k.eor = 1'b0; k.ovf = ovf_seen;
      kept_q.push_back(k);
    end
    if (kept_q.size() > first_idx) kept_q[kept_q.size()-1].eor = 1'b1;
    n_held   = 0;
    ovf_seen = 1'b0;
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // offer one box; valid stays high afterwards so beats can follow back to back
  task automatic send_box(box_t bx, logic fin);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      box_in.valid <= 1'b0;
      @(negedge clk);
    end
    box_in.valid       <= 1'b1;
    box_in.score       <= bx.score;
    box_in.left_edge   <= bx.left;
    box_in.top_edge    <= bx.top;
    box_in.right_edge  <= bx.right;
    box_in.bottom_edge <= bx.bottom;
    box_in.final_box   <= fin;
    do @(posedge clk); while (!box_in.ready);
    predict_box(bx, fin);
    @(negedge clk);
  endtask

  // drop the box channel, wait for the block to drain, then write the threshold
  task automatic write_threshold(logic [15:0] v);
    box_in.valid <= 1'b0;
    while (kept_q.size() != 0) @(negedge clk);
    repeat (4 * CAP + 40) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    thr = v;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic box_t mk(int s, int l, int t, int r, int b);
    box_t x;
    x.score = 16'(s); x.left = 16'(l); x.top = 16'(t); x.right = 16'(r);
    x.bottom = 16'(b);
    return x;
  endfunction

  function automatic box_t rand_box();
    box_t x;
    int   cx, cy;
    if ($urandom_range(9) == 0) begin
      x = mk($urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      cx = int'($urandom_range(4000)) - 2000;
      cy = int'($urandom_range(4000)) - 2000;
      x = mk($urandom_range(65535), cx, cy,
             cx + int'($urandom_range(3000)), cy + int'($urandom_range(3000)));
    end
    return x;
  endfunction

  // a clustered set with random content
  task automatic send_random_set(int n);
    for (int i = 0; i < n; i++) send_box(rand_box(), i == n - 1);
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (!rst && kept_out.valid && kept_out.ready) begin
      if (kept_q.size() == 0) begin
        report_mismatch("unexpected kept beat, score", kept_out.kept_score, 0);
      end else begin
        kept_t w;
        w = kept_q.pop_front();
        if (kept_out.kept_score !== w.score)
          report_mismatch("kept_score", kept_out.kept_score, w.score);
        if (kept_out.kept_left !== w.l) report_mismatch("kept_left", kept_out.kept_left, w.l);
        if (kept_out.kept_top !== w.t) report_mismatch("kept_top", kept_out.kept_top, w.t);
        if (kept_out.kept_right !== w.r)
          report_mismatch("kept_right", kept_out.kept_right, w.r);
        if (kept_out.kept_bottom !== w.b)
          report_mismatch("kept_bottom", kept_out.kept_bottom, w.b);
        if (kept_out.end_of_run !== w.eor)
          report_mismatch("end_of_run", kept_out.end_of_run, w.eor);
        if (kept_out.overflowed !== w.ovf)
          report_mismatch("overflowed", kept_out.overflowed, w.ovf);
      end
    end
  end

  // receiver ready: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rst) kept_out.ready <= 1'b0;
    else if (hold_off) kept_out.ready <= 1'b0;
    else kept_out.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((box_in.valid && box_in.ready) || (kept_out.valid && kept_out.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("greedy_box_suppression test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    // extremes of every field, ties in input order, degenerate boxes
    send_box(mk(16'hFFFF, -32768, -32768, 32767, 32767), 1'b1);
    send_box(mk(0, 0, 0, 0, 0), 1'b1);
    send_box(mk(100, 0, 0, 100, 100), 1'b0);
    send_box(mk(100, 10, 10, 110, 110), 1'b0);
    send_box(mk(100, 500, 500, 600, 600), 1'b0);
    send_box(mk(200, 5, 5, -5, -5), 1'b0);
    send_box(mk(50, 32767, 32767, -32768, -32768), 1'b1);
    send_box(mk(16'h8000, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF), 1'b0);
    send_box(mk(16'h7FFF, 16'hAAAA, 16'h5555, 16'h7FFF, 16'h7FFF), 1'b1);
  endtask

  task automatic test_thresholds();
    logic [15:0] vals[4] = '{16'd0, 16'hFFFF, 16'd1, 16'd16384};
    foreach (vals[i]) begin
      write_threshold(vals[i]);
      send_box(mk(900, 0, 0, 1000, 1000), 1'b0);
      send_box(mk(800, 0, 0, 1000, 1000), 1'b0);
      send_box(mk(700, 500, 0, 1500, 1000), 1'b0);
      send_box(mk(600, 5000, 5000, 6000, 6000), 1'b1);
    end
    write_threshold(16'd32768);
  endtask

  task automatic test_overflow();
    // small boxes far apart so that most survive
    for (int i = 0; i < CAP + 3; i++)
      send_box(mk($urandom_range(65535), i * 400 - 16000, 0, i * 400 - 15900, 100),
               i == CAP + 2);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        send_random_set(6);
        send_random_set(5);
      end
    join
  endtask

  task automatic test_random(int sets);
    for (int i = 0; i < sets; i++) begin
      if (i % 4 == 3) write_threshold(16'($urandom));
      send_random_set($urandom_range(1, 8));
    end
  endtask

  initial begin
    errors = 0; idle_cycles = 0; hold_off = 1'b0;
    send_idle_pct = 0; recv_idle_pct = 0;
    thr = THR_RESET; n_held = 0; ovf_seen = 1'b0;
    box_in.valid = 1'b0; box_in.score = '0; box_in.left_edge = '0;
    box_in.top_edge = '0; box_in.right_edge = '0; box_in.bottom_edge = '0;
    box_in.final_box = 1'b0;
    kept_out.ready = 1'b0;
    cfg.valid = 1'b0; cfg.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_thresholds();
    test_overflow();
    send_idle_pct = 32; recv_idle_pct = 63;
    test_random(6);
    test_backpressure();
    send_idle_pct = 63; recv_idle_pct = 32;
    test_random(6);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(6);

    box_in.valid <= 1'b0;
    while (kept_q.size() != 0) @(negedge clk);
    repeat (4 * CAP + 40) @(negedge clk);
    if (errors == 0)
      $display("greedy_box_suppression test passed");
    else
      $display("greedy_box_suppression test failed");
    $finish;
  end

endmodule
